FILE: hw/rtl/ssh_pkg.sv
// ============================================================================
// ssh_pkg
// Shared constants and word functions for the SHA-256 stream hasher:
// initial hash values, round constants and the sigma functions.
// ============================================================================
package ssh_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned NumRounds = 64;
    localparam int unsigned NumHash   = 8;
    localparam logic [7:0]  PadMark   = 8'h80;

    // Initial chaining value H0..H7
    localparam word_t INIT_HASH [NumHash] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants K0..K63
    localparam word_t ROUND_K [NumRounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

FILE: hw/rtl/sha256_stream_hasher_unit.sv
// ============================================================================
// sha256_stream_hasher_unit
// SHA-256 over a byte stream: block packing, one round per cycle,
// padding sequencer and an eight-beat digest output.
// ============================================================================
// Use:
//   Input channel (in_valid/in_ready) takes one beat per item: data_byte,
//   byte_present and end_of_message. in_ready is high only while the unit
//   is idle. A beat with a byte is absorbed in the cycle it is accepted.
//   The 64th byte of a block starts a compression (load, 64 rounds on the
//   single round unit, fold into the chaining state); in_ready stays low
//   until it is done, so no byte is taken meanwhile.
//   On end_of_message the sequencer pushes 0x80, zero fill and the 64-bit
//   bit length one byte per cycle, pausing while a block is hashed, and
//   runs one or two compressions. It then presents the digest on the output
//   channel (out_valid/out_ready) as eight beats, H0 first, with word_index
//   and last_word. Each digest word waits in place while out_ready is low.
//   After the eighth beat the unit returns to the initial hash value.
//   Reset (rst_n low) returns it to that state at once; there is no
//   clearing pass.
// ============================================================================
module sha256_stream_hasher_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                byte_present,
    input  logic                end_of_message,
    output logic                out_valid,
    input  logic                out_ready,
    output ssh_pkg::word_t      digest_word,
    output logic [2:0]          word_index,
    output logic                last_word
);
    import ssh_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [5:0]             fill_reg, fill_next;
    logic [60:0]            count_reg, count_next;
    logic [5:0]             round_reg, round_next;
    logic [2:0]             idx_reg, idx_next;
    logic                   pad_reg, pad_next;      // padding under way
    logic                   mark_reg, mark_next;    // 0x80 already pushed
    logic                   len_reg, len_next;      // length bytes under way
    logic                   final_reg, final_next;  // last block queued
    logic [511:0]           blk_reg, blk_next;
    logic [7:0][31:0]       var_reg, var_next;
    logic [7:0][31:0]       hash_reg, hash_next;

    logic                   in_fire, out_fire;
    logic                   push_go;
    logic [7:0]             push_val;
    logic [63:0]            len_shift;
    logic                   len_byte;
    word_t                  w0, w1, w9, w14, w_new;
    word_t                  t1, t2;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = hash_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

    // Schedule window: word k sits at bits 511-32k down
    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];
    assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

    // Round unit
    assign t1 = var_reg[7] + big_sigma1(var_reg[4])
              + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
              + ROUND_K[round_reg] + w0;
    assign t2 = big_sigma0(var_reg[0])
              + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                 ^ (var_reg[1] & var_reg[2]));

    // Select the length byte for block positions 56..63
    assign len_shift = {count_reg, 3'b000} << {fill_reg[2:0], 3'b000};
    assign len_byte  = mark_reg && (len_reg || (fill_reg == 6'd56));

    // Pick the byte to push this cycle
    always_comb
    begin
        push_go  = 1'b0;
        push_val = data_byte;
        if (state_reg == ST_IDLE)
        begin
            push_go = in_fire && byte_present;
        end
        else if (state_reg == ST_PAD)
        begin
            push_go = 1'b1;
            if (!mark_reg)
            begin
                push_val = PadMark;
            end
            else if (len_byte)
            begin
                push_val = len_shift[63:56];
            end
            else
            begin
                push_val = 8'h00;
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        pad_next   = pad_reg;
        mark_next  = mark_reg;
        len_next   = len_reg;
        final_next = final_reg;
        blk_next   = blk_reg;
        var_next   = var_reg;
        hash_next  = hash_reg;

        // Absorb one byte into the block
        if (push_go)
        begin
            blk_next  = {blk_reg[503:0], push_val};
            fill_next = fill_reg + 6'd1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (byte_present)
                    begin
                        count_next = count_reg + 61'd1;
                    end
                    if (end_of_message)
                    begin
                        pad_next = 1'b1;
                    end
                    if (byte_present && (fill_reg == 6'd63))
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                mark_next = 1'b1;
                if (len_byte)
                begin
                    len_next = 1'b1;
                    if (fill_reg == 6'd63)
                    begin
                        final_next = 1'b1;
                    end
                end
                if (fill_reg == 6'd63)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                var_next   = hash_reg;
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                blk_next   = {blk_reg[479:0], w_new};
                var_next   = {var_reg[6:4], var_reg[3] + t1, var_reg[2:0], t1 + t2};
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                for (int i = 0; i < NumHash; i++)
                begin
                    hash_next[i] = hash_reg[i] + var_reg[i];
                end
                idx_next = '0;
                if (final_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        // Restart on the initial vector
                        for (int i = 0; i < NumHash; i++)
                        begin
                            hash_next[i] = INIT_HASH[i];
                        end
                        fill_next  = '0;
                        count_next = '0;
                        pad_next   = 1'b0;
                        mark_next  = 1'b0;
                        len_next   = 1'b0;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            count_reg <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            pad_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            len_reg   <= 1'b0;
            final_reg <= 1'b0;
            for (int i = 0; i < NumHash; i++)
            begin
                hash_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            pad_reg   <= pad_next;
            mark_reg  <= mark_next;
            len_reg   <= len_next;
            final_reg <= final_next;
            hash_reg  <= hash_next;
        end
    end

    // Block window and round variables hold payload only
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        var_reg <= var_next;
    end

endmodule
